>>> design/utf8dec_pkg.sv
// Shared types, constants and byte helpers for the UTF-8 decoder.
package utf8dec_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 4;

  localparam logic [20:0] CP_BOM     = 21'h00FEFF;
  localparam logic [20:0] CP_MAX     = 21'h10FFFF;
  localparam logic [20:0] CP_SUPP    = 21'h010000;
  localparam logic [20:0] CP_HI_SURR = 21'h00D800;
  localparam logic [20:0] CP_LO_SURR = 21'h00DC00;
  localparam logic [20:0] CP_2B_MAX  = 21'h0007FF;

  localparam logic [20:0] CP_2B_MIN  = 21'h000080;
  localparam logic [20:0] CP_3B_MIN  = 21'h000800;

  typedef enum logic [2:0] {
    CLS_ASCII,
    CLS_RAW,
    CLS_LEAD2,
    CLS_LEAD3,
    CLS_LEAD4
  } byte_cls_t;

  // One queued input word.
  typedef struct packed {
    logic [7:0] data;
    byte_cls_t  cls;
    logic       eob;
  } item_t;

  // Verdict on a complete multi-byte sequence.
  typedef struct packed {
    logic        ok;
    logic        is_unit;   // 2 or 3 byte form, goes through surrogate joining
    logic [20:0] value;
  } dec_t;

  function automatic byte_cls_t classify(input logic [7:0] b);
    byte_cls_t c;
    if (b < 8'h80) begin
      c = CLS_ASCII;
    end else if (b inside {[8'h80:8'hBF], [8'hF8:8'hFF]}) begin
      c = CLS_RAW;
    end else if (b >= 8'hF0) begin
      c = CLS_LEAD4;
    end else if (b >= 8'hE0) begin
      c = CLS_LEAD3;
    end else begin
      c = CLS_LEAD2;
    end
    return c;
  endfunction

  function automatic logic [2:0] seq_len(input byte_cls_t c);
    logic [2:0] n;
    case (c)
      CLS_LEAD4: n = 3'd4;
      CLS_LEAD3: n = 3'd3;
      default:   n = 3'd2;
    endcase
    return n;
  endfunction

  function automatic logic is_cont(input logic [7:0] b);
    return b[7:6] == 2'b10;
  endfunction

  function automatic dec_t decode(input logic [7:0] b0, input logic [7:0] b1,
                                  input logic [7:0] b2, input logic [7:0] b3,
                                  input logic [2:0] need);
    dec_t d;
    d = '0;
    case (need)
      3'd2: begin
        d.value   = {10'd0, b0[4:0], b1[5:0]};
        d.is_unit = 1'b1;
        d.ok      = is_cont(b1) && (d.value >= CP_2B_MIN) && (d.value <= CP_2B_MAX);
      end
      3'd3: begin
        d.value   = {5'd0, b0[3:0], b1[5:0], b2[5:0]};
        d.is_unit = 1'b1;
        d.ok      = is_cont(b1) && is_cont(b2) && (d.value >= CP_3B_MIN);
      end
      default: begin
        d.value   = {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
        d.is_unit = 1'b0;
        d.ok      = is_cont(b1) && is_cont(b2) && is_cont(b3)
                    && (d.value >= CP_SUPP) && (d.value <= CP_MAX);
      end
    endcase
    return d;
  endfunction

endpackage

>>> design/utf8dec_front.sv
// Front end: accepts input words, classifies each byte and queues it.
module utf8dec_front #(
  parameter int unsigned DEPTH = utf8dec_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [7:0]          in_tdata,
  input  logic                in_tlast,
  output utf8dec_pkg::item_t  q_item,
  output logic                q_valid,
  input  logic                q_ready
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  utf8dec_pkg::item_t mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               push, pop;
  utf8dec_pkg::item_t new_item;

  assign in_tready = cnt_r != CNT_W'(DEPTH);
  assign q_valid   = cnt_r != '0;
  assign q_item    = mem_r[rd_ptr_r];
  assign push      = in_tvalid && in_tready;
  assign pop       = q_valid && q_ready;

  always_comb begin
    new_item.data = in_tdata;
    new_item.cls  = utf8dec_pkg::classify(in_tdata);
    new_item.eob  = in_tlast;
  end

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + CNT_W'(1);
      2'b01:   cnt_nxt = cnt_r - CNT_W'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= new_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(DEPTH))
    else $error("front queue count beyond depth");

  a_pop_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !push) |=> (cnt_r == $past(cnt_r) - CNT_W'(1)))
    else $error("front queue pop did not drain an entry");

endmodule

>>> design/utf8dec_back.sv
// Back end: sequence gathering, replay on error, surrogate joining, result output.
module utf8dec_back (
  input  logic               clk,
  input  logic               rst_n,
  input  utf8dec_pkg::item_t item,
  input  logic               item_valid,
  output logic               item_ready,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [23:0]        out_tdata,
  output logic [1:0]         out_tuser,
  output logic               out_tlast
);

  typedef enum logic [1:0] {
    S_FETCH,
    S_RUN,
    S_JUDGE
  } state_t;

  state_t                 state_r, state_nxt;
  logic                   step_active_r, step_active_nxt;
  logic                   last_r, last_nxt;

  // replay queue, head at index 0
  logic [7:0]             q_byte_r [3];
  logic [7:0]             q_byte_nxt [3];
  utf8dec_pkg::byte_cls_t q_cls_r [3];
  utf8dec_pkg::byte_cls_t q_cls_nxt [3];
  logic [1:0]             qn_r, qn_nxt;

  logic [7:0]             pend_r [4];
  logic [7:0]             pend_nxt [4];
  logic [1:0]             pcnt_r, pcnt_nxt;
  logic [2:0]             need_r, need_nxt;

  logic [9:0]             held_r, held_nxt;
  logic                   held_valid_r, held_valid_nxt;

  // last result of the running step, kept back until its end flag is known
  logic                   cand_valid_r, cand_valid_nxt;
  logic [20:0]            cand_cp_r, cand_cp_nxt;
  logic                   cand_raw_r, cand_raw_nxt;

  logic                   out_valid_r, out_valid_nxt;
  logic [20:0]            out_cp_r, out_cp_nxt;
  logic                   out_raw_r, out_raw_nxt;
  logic [1:0]             out_tail_r, out_tail_nxt;
  logic                   out_nochar_r, out_nochar_nxt;
  logic                   out_last_r, out_last_nxt;

  logic                   out_free, emit_ok, emit_req, emit_raw, do_pop, go_next;
  logic                   finish_ok;
  logic [20:0]            emit_cp, held_cp, pair_cp;
  logic [1:0]             rep_n;
  logic [2:0]             rep_total;
  logic                   is_bom, is_hi, is_lo;
  utf8dec_pkg::dec_t      dec;

  assign dec     = utf8dec_pkg::decode(pend_r[0], pend_r[1], pend_r[2], pend_r[3], need_r);
  assign is_bom  = dec.value == utf8dec_pkg::CP_BOM;
  assign is_hi   = dec.value[20:10] == utf8dec_pkg::CP_HI_SURR[20:10];
  assign is_lo   = dec.value[20:10] == utf8dec_pkg::CP_LO_SURR[20:10];
  assign held_cp = utf8dec_pkg::CP_HI_SURR | {11'd0, held_r};
  assign pair_cp = utf8dec_pkg::CP_SUPP + {1'b0, held_r, dec.value[9:0]};
  assign rep_n     = 2'(need_r - 3'd1);
  assign rep_total = {1'b0, qn_r} + {1'b0, rep_n};

  assign out_free = !out_valid_r || out_tready;
  assign emit_ok  = !cand_valid_r || out_free;

  always_comb begin
    state_nxt       = state_r;
    step_active_nxt = step_active_r;
    last_nxt        = last_r;
    q_byte_nxt      = q_byte_r;
    q_cls_nxt       = q_cls_r;
    qn_nxt          = qn_r;
    pend_nxt        = pend_r;
    pcnt_nxt        = pcnt_r;
    need_nxt        = need_r;
    held_nxt        = held_r;
    held_valid_nxt  = held_valid_r;
    cand_valid_nxt  = cand_valid_r;
    cand_cp_nxt     = cand_cp_r;
    cand_raw_nxt    = cand_raw_r;
    out_valid_nxt   = out_valid_r && !out_tready;
    out_cp_nxt      = out_cp_r;
    out_raw_nxt     = out_raw_r;
    out_tail_nxt    = out_tail_r;
    out_nochar_nxt  = out_nochar_r;
    out_last_nxt    = out_last_r;
    item_ready      = 1'b0;
    emit_req        = 1'b0;
    emit_cp         = '0;
    emit_raw        = 1'b0;
    do_pop          = 1'b0;
    go_next         = 1'b0;
    finish_ok       = 1'b0;

    case (state_r)
      S_FETCH: begin
        if (step_active_r && last_r && held_valid_r) begin
          // buffer end: a held high surrogate goes out alone
          emit_req = 1'b1;
          emit_cp  = held_cp;
          if (emit_ok) begin
            held_valid_nxt = 1'b0;
          end
        end else begin
          finish_ok = !step_active_r || !(cand_valid_r || last_r) || out_free;
          if (finish_ok) begin
            if (step_active_r) begin
              if (cand_valid_r || last_r) begin
                out_valid_nxt  = 1'b1;
                out_cp_nxt     = cand_valid_r ? cand_cp_r : '0;
                out_raw_nxt    = cand_valid_r && cand_raw_r;
                out_nochar_nxt = !cand_valid_r;
                out_last_nxt   = last_r;
                out_tail_nxt   = last_r ? pcnt_r : 2'd0;
              end
              cand_valid_nxt  = 1'b0;
              step_active_nxt = 1'b0;
            end
            item_ready = 1'b1;
            if (item_valid) begin
              q_byte_nxt[0]   = item.data;
              q_cls_nxt[0]    = item.cls;
              qn_nxt          = 2'd1;
              last_nxt        = item.eob;
              step_active_nxt = 1'b1;
              state_nxt       = S_RUN;
            end
          end
        end
      end

      S_RUN: begin
        if (pcnt_r == 2'd0) begin
          if (q_cls_r[0] == utf8dec_pkg::CLS_ASCII || q_cls_r[0] == utf8dec_pkg::CLS_RAW) begin
            emit_req = 1'b1;
            if (held_valid_r) begin
              emit_cp = held_cp;
              if (emit_ok) begin
                held_valid_nxt = 1'b0;
              end
            end else begin
              emit_cp  = {13'd0, q_byte_r[0]};
              emit_raw = q_cls_r[0] == utf8dec_pkg::CLS_RAW;
              do_pop   = emit_ok;
            end
          end else begin
            pend_nxt[0] = q_byte_r[0];
            pcnt_nxt    = 2'd1;
            need_nxt    = utf8dec_pkg::seq_len(q_cls_r[0]);
            do_pop      = 1'b1;
          end
        end else begin
          pend_nxt[pcnt_r] = q_byte_r[0];
          do_pop           = 1'b1;
          if ({1'b0, pcnt_r} + 3'd1 == need_r) begin
            pcnt_nxt  = 2'd0;
            state_nxt = S_JUDGE;
          end else begin
            pcnt_nxt = pcnt_r + 2'd1;
          end
        end
        if (do_pop) begin
          q_byte_nxt[0] = q_byte_r[1];
          q_byte_nxt[1] = q_byte_r[2];
          q_cls_nxt[0]  = q_cls_r[1];
          q_cls_nxt[1]  = q_cls_r[2];
          qn_nxt        = qn_r - 2'd1;
          if (qn_r == 2'd1 && state_nxt == S_RUN) begin
            state_nxt = S_FETCH;
          end
        end
      end

      S_JUDGE: begin
        if (!dec.ok) begin
          emit_req = 1'b1;
          if (held_valid_r) begin
            emit_cp = held_cp;
            if (emit_ok) begin
              held_valid_nxt = 1'b0;
            end
          end else begin
            // lead goes out raw, the rest is fed back in front of the queue
            emit_cp  = {13'd0, pend_r[0]};
            emit_raw = 1'b1;
            if (emit_ok) begin
              q_byte_nxt[0] = pend_r[1];
              q_cls_nxt[0]  = utf8dec_pkg::classify(pend_r[1]);
              if (rep_n >= 2'd2) begin
                q_byte_nxt[1] = pend_r[2];
                q_cls_nxt[1]  = utf8dec_pkg::classify(pend_r[2]);
              end else begin
                q_byte_nxt[1] = q_byte_r[0];
                q_cls_nxt[1]  = q_cls_r[0];
              end
              if (rep_n == 2'd3) begin
                q_byte_nxt[2] = pend_r[3];
                q_cls_nxt[2]  = utf8dec_pkg::classify(pend_r[3]);
              end else if (rep_n == 2'd2) begin
                q_byte_nxt[2] = q_byte_r[0];
                q_cls_nxt[2]  = q_cls_r[0];
              end else begin
                q_byte_nxt[2] = q_byte_r[1];
                q_cls_nxt[2]  = q_cls_r[1];
              end
              qn_nxt    = rep_total[1:0];
              state_nxt = S_RUN;
            end
          end
        end else if (!dec.is_unit) begin
          emit_req = 1'b1;
          if (held_valid_r) begin
            emit_cp = held_cp;
            if (emit_ok) begin
              held_valid_nxt = 1'b0;
            end
          end else begin
            emit_cp = dec.value;
            go_next = emit_ok;
          end
        end else if (is_bom) begin
          go_next = 1'b1;
        end else if (is_hi) begin
          // a new high surrogate pushes out any older one
          if (held_valid_r) begin
            emit_req = 1'b1;
            emit_cp  = held_cp;
          end
          if (!held_valid_r || emit_ok) begin
            held_nxt       = dec.value[9:0];
            held_valid_nxt = 1'b1;
            go_next        = 1'b1;
          end
        end else if (is_lo && held_valid_r) begin
          emit_req = 1'b1;
          emit_cp  = pair_cp;
          if (emit_ok) begin
            held_valid_nxt = 1'b0;
            go_next        = 1'b1;
          end
        end else begin
          emit_req = 1'b1;
          if (held_valid_r) begin
            emit_cp = held_cp;
            if (emit_ok) begin
              held_valid_nxt = 1'b0;
            end
          end else begin
            emit_cp = dec.value;
            go_next = emit_ok;
          end
        end
        if (go_next) begin
          state_nxt = (qn_r == 2'd0) ? S_FETCH : S_RUN;
        end
      end

      default: begin
        state_nxt = S_FETCH;
      end
    endcase

    // a new result displaces the held-back one to the output register
    if (emit_req && emit_ok) begin
      if (cand_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_cp_nxt     = cand_cp_r;
        out_raw_nxt    = cand_raw_r;
        out_nochar_nxt = 1'b0;
        out_last_nxt   = 1'b0;
        out_tail_nxt   = 2'd0;
      end
      cand_valid_nxt = 1'b1;
      cand_cp_nxt    = emit_cp;
      cand_raw_nxt   = emit_raw;
    end
  end

  always_ff @(posedge clk) begin
    q_byte_r   <= q_byte_nxt;
    q_cls_r    <= q_cls_nxt;
    pend_r     <= pend_nxt;
    cand_cp_r  <= cand_cp_nxt;
    cand_raw_r <= cand_raw_nxt;
    out_cp_r     <= out_cp_nxt;
    out_raw_r    <= out_raw_nxt;
    out_tail_r   <= out_tail_nxt;
    out_nochar_r <= out_nochar_nxt;
    out_last_r   <= out_last_nxt;
    last_r       <= last_nxt;
    need_r       <= need_nxt;
    if (!rst_n) begin
      state_r       <= S_FETCH;
      step_active_r <= 1'b0;
      qn_r          <= 2'd0;
      pcnt_r        <= 2'd0;
      held_r        <= '0;
      held_valid_r  <= 1'b0;
      cand_valid_r  <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      step_active_r <= step_active_nxt;
      qn_r          <= qn_nxt;
      pcnt_r        <= pcnt_nxt;
      held_r        <= held_nxt;
      held_valid_r  <= held_valid_nxt;
      cand_valid_r  <= cand_valid_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_tail_r, out_cp_r};
  assign out_tuser  = {out_nochar_r, out_raw_r};
  assign out_tlast  = out_last_r;

  a_run_has_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_RUN |-> qn_r != 2'd0)
    else $error("processing state entered with empty replay queue");

  a_replay_fits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_JUDGE && !dec.ok && !held_valid_r) |-> rep_total <= 3'd3)
    else $error("replay would overflow the replay queue");

  a_marker_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_nochar_r) |-> out_last_r)
    else $error("end marker word without end flag");

endmodule

>>> design/utf8_to_code_point_decoder.sv
// Top level of the UTF-8 to code point decoder: input queue and decode engine.
//
//  channel | dir | tdata                               | tuser                  | tlast
//  in_     | in  | [7:0] data_byte                     | -                      | end_of_buffer
//  out_    | out | [20:0] code_point, [22:21] tail     | [0] raw_err, [1] no_ch | last_of_run
//
// Steps: the decode engine fetches each byte from the input queue, then processes
// it; the byte that completes a sequence gets a verdict step, each byte fed back
// after a bad sequence is processed again, a held high surrogate pushed out takes
// its own step, and the next byte is fetched only when the current one is done.
// Reset is synchronous, active low; it empties the input queue and clears the
// pending-sequence count, the held surrogate and all valid flags.
// The input queue keeps taking words, until it is full, while the engine is stalled on out_tready;
// the last result of a word is kept back until the word is done so that the
// end-of-buffer flag can be set on it.
module utf8_to_code_point_decoder #(
  parameter int unsigned QUEUE_DEPTH = utf8dec_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] data_byte
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,   // [20:0] code_point, [22:21] tail_bytes, [23] zero
  output logic [1:0]  out_tuser,   // [0] raw_error, [1] no_char
  output logic        out_tlast
);

  utf8dec_pkg::item_t q_item;
  logic               q_valid;
  logic               q_ready;

  // front: accept and classify bytes
  utf8dec_front #(
    .DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .q_item    (q_item),
    .q_valid   (q_valid),
    .q_ready   (q_ready)
  );

  // back: gather, judge, replay, join surrogates, emit
  utf8dec_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .item       (q_item),
    .item_valid (q_valid),
    .item_ready (q_ready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
